@@ hdl/alc_pkg.sv @@
// ----------------------------------------------------------------------------
// alc_pkg
// Shared types, constants and the table root function for the lux
// calculation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

    localparam int RATIO_FRAC_BITS_DEF   = 16;
    localparam int POW_TABLE_ENTRIES_DEF = 256;

    localparam int CNT_W  = 16;
    localparam int LUX_W  = 23;
    localparam int P_W    = 16;
    localparam int COEF_W = 24;
    localparam int X_W    = 33;
    localparam int C_W    = 23;
    localparam int BBC_W  = CNT_W + C_W;
    localparam int Q0_W   = 24;
    localparam int DIV_W  = 12;
    localparam int RECIP_W  = 24;
    localparam int RECIP_SH = 33;

    localparam logic [CNT_W-1:0] SAT_CODE = 16'hffff;
    localparam logic [LUX_W-1:0] LUX_MAX  = 23'd8388607;

    // low region: bb * (A_BASE - 155 p) / (64 * 625)
    localparam logic [C_W-1:0]    A_BASE    = 23'd4980736;
    localparam logic [COEF_W-1:0] COEF_A_P  = 24'd155;
    localparam int                A_SHIFT   = 6;

    localparam logic [COEF_W-1:0] COEF_B_BB = 24'd112;
    localparam logic [COEF_W-1:0] COEF_B_IR = 24'd155;
    localparam logic [COEF_W-1:0] COEF_C_BB = 24'd128;
    localparam logic [COEF_W-1:0] COEF_C_IR = 24'd153;
    localparam logic [COEF_W-1:0] COEF_D_BB = 24'd146;
    localparam logic [COEF_W-1:0] COEF_D_IR = 24'd112;
    localparam int LIN_SH_B = 9;
    localparam int LIN_SH_C = 8;
    localparam int LIN_SH_D = 7;

    localparam logic [DIV_W-1:0]   DIV_SMALL   = 12'd625;
    localparam logic [DIV_W-1:0]   DIV_BIG     = 12'd3125;
    localparam logic [RECIP_W-1:0] RECIP_SMALL = 24'd13743895;
    localparam logic [RECIP_W-1:0] RECIP_BIG   = 24'd2748779;

    typedef enum logic [2:0] {
        RGN_A,
        RGN_B,
        RGN_C,
        RGN_D,
        RGN_NONE
    } t_region;

    typedef struct packed {
        logic [CNT_W-1:0] bb;
        logic [CNT_W-1:0] ir;
        t_region          region;
    } t_side;

    // largest s with s^5 * m^2 <= idx^2 * 2^80
    function automatic logic [P_W-1:0] pow_root(input int unsigned idx,
                                                input int unsigned tbl_m);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] m2;
        logic [16:0]  lo_s;
        logic [16:0]  hi_s;
        logic [16:0]  mid;
        rhs  = (128'(idx) * 128'(idx)) << 80;
        m2   = 128'(tbl_m) * 128'(tbl_m);
        lo_s = '0;
        hi_s = 17'd65535;
        for (int k = 0; k < 17; k++) begin
            if (lo_s < hi_s) begin
                mid = 17'((18'(lo_s) + 18'(hi_s) + 18'd1) >> 1);
                lhs = 128'(mid) * 128'(mid);
                lhs = lhs * lhs * 128'(mid) * m2;
                if (lhs <= rhs) begin
                    lo_s = mid;
                end else begin
                    hi_s = mid - 17'd1;
                end
            end
        end
        return lo_s[P_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/alc_div_stage.sv @@
// ----------------------------------------------------------------------------
// alc_div_stage
// One restoring step of the ratio divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_div_stage import alc_pkg::*; #(
    parameter int QUO_W = RATIO_FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_side            i_side,
    input  wire logic [CNT_W-1:0] i_rem,
    input  wire logic [QUO_W-1:0] i_quo,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [CNT_W-1:0]      o_rem,
    output logic [QUO_W-1:0]      o_quo
);

    logic             r_valid;
    t_side            r_side;
    logic [CNT_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;

    logic [CNT_W:0]   w_two;
    logic [CNT_W:0]   w_diff;
    logic             w_bit;

    assign w_two  = {i_rem, 1'b0};
    assign w_bit  = (w_two >= {1'b0, i_side.bb});
    assign w_diff = w_two - {1'b0, i_side.bb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= w_bit ? w_diff[CNT_W-1:0] : w_two[CNT_W-1:0];
            r_quo  <= {i_quo[QUO_W-2:0], w_bit};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

`default_nettype wire

@@ hdl/alc_pow_rom.sv @@
// ----------------------------------------------------------------------------
// alc_pow_rom
// Constant ratio^1.4 table in Q16 with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_pow_rom import alc_pkg::*; #(
    parameter int POW_TABLE_ENTRIES = POW_TABLE_ENTRIES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic [$clog2(POW_TABLE_ENTRIES)-1:0] i_idx,
    output logic [P_W-1:0]                            o_p
);

    localparam int unsigned TBL_M = 2 * POW_TABLE_ENTRIES;

    logic [P_W-1:0] w_rom [POW_TABLE_ENTRIES];
    logic [P_W-1:0] r_p;

    for (genvar gi = 0; gi < POW_TABLE_ENTRIES; gi++) begin : g_rom
        localparam logic [P_W-1:0] Root = pow_root(gi, TBL_M);
        localparam logic [47:0]    Prod = 48'(gi) * 48'(Root);
        assign w_rom[gi] = P_W'(Prod / TBL_M);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_rom[i_idx];
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ hdl/alc_const_div.sv @@
// ----------------------------------------------------------------------------
// alc_const_div
// Divide by 625 or 3125 via reciprocal multiply, one-step correction and
// output clamp. Holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_const_div import alc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [X_W-1:0]   i_x,
    input  wire logic             i_big,
    input  wire logic             i_zero,
    output logic                  o_valid,
    output logic [LUX_W-1:0]      o_q
);

    localparam int PROD_W = X_W + RECIP_W;
    localparam int QD_W   = Q0_W + DIV_W;

    logic [PROD_W-1:0] w_prod;
    logic [QD_W-1:0]   w_qd;
    logic [X_W-1:0]    w_rem;
    logic [DIV_W-1:0]  w_d2;
    logic [Q0_W:0]     w_q;

    logic              r_v1;
    logic [Q0_W-1:0]   r_q0_1;
    logic [X_W-1:0]    r_x1;
    logic              r_big1;
    logic              r_zero1;

    logic              r_v2;
    logic [Q0_W-1:0]   r_q0_2;
    logic [X_W-1:0]    r_qd2;
    logic [X_W-1:0]    r_x2;
    logic              r_big2;
    logic              r_zero2;

    logic              r_v3;
    logic [LUX_W-1:0]  r_q;

    assign w_prod = PROD_W'(i_x) * PROD_W'(i_big ? RECIP_BIG : RECIP_SMALL);
    assign w_qd   = QD_W'(r_q0_1) * QD_W'(r_big1 ? DIV_BIG : DIV_SMALL);
    assign w_d2   = r_big2 ? DIV_BIG : DIV_SMALL;
    assign w_rem  = r_x2 - r_qd2;
    assign w_q    = (w_rem >= X_W'(w_d2)) ? ({1'b0, r_q0_2} + 1'b1) : {1'b0, r_q0_2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0_1  <= w_prod[RECIP_SH +: Q0_W];
            r_x1    <= i_x;
            r_big1  <= i_big;
            r_zero1 <= i_zero;

            r_q0_2  <= r_q0_1;
            r_qd2   <= w_qd[X_W-1:0];
            r_x2    <= r_x1;
            r_big2  <= r_big1;
            r_zero2 <= r_zero1;

            if (r_zero2) begin
                r_q <= '0;
            end else if (w_q > (Q0_W+1)'(LUX_MAX)) begin
                r_q <= LUX_MAX;
            end else begin
                r_q <= w_q[LUX_W-1:0];
            end
        end
    end

    assign o_valid = r_v3;
    assign o_q     = r_q;

endmodule

`default_nettype wire

@@ hdl/ambient_light_lux_calc_core.sv @@
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_core
// Two-channel light sensor lux approximation, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one broadband/infrared count word per clock and returns lux * 256
// (truncated, clamped to zero) in the same order, one word per clock when
// the output side keeps ready high. The pipeline holds one input stage, one
// divider stage per ratio fraction bit, index and linear terms, table read,
// coefficient, product, and three stages of constant division ending in the
// output register. A low ready on the output holds the whole pipeline;
// nothing is dropped or repeated.
// Saturated counts (0xffff), a zero broadband count and a ratio of 1.3 or
// more give zero.
`default_nettype none

module ambient_light_lux_calc_core import alc_pkg::*; #(
    parameter int RATIO_FRAC_BITS   = RATIO_FRAC_BITS_DEF,
    parameter int POW_TABLE_ENTRIES = POW_TABLE_ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [CNT_W-1:0] i_broadband_count,
    input  wire logic [CNT_W-1:0] i_infrared_count,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [LUX_W-1:0]      o_lux_q8
);

    localparam int TBL_M = 2 * POW_TABLE_ENTRIES;
    localparam int M_W   = $clog2(TBL_M) + 1;
    localparam int IDX_W = $clog2(POW_TABLE_ENTRIES);
    localparam int PRD_W = RATIO_FRAC_BITS + M_W;
    localparam int F     = RATIO_FRAC_BITS;

    typedef struct packed {
        logic [CNT_W-1:0] bb;
        logic [X_W-1:0]   lin;
        t_region          region;
    } t_tail;

    logic w_en;

    // input stage
    logic [COEF_W-1:0] w_ir100, w_bb61, w_ir10, w_bb8, w_bb13;
    t_region           w_region;
    logic              r_s0_valid;
    t_side             r_s0_side;

    // divider chain
    logic             w_dv_valid [F+1];
    t_side            w_dv_side  [F+1];
    logic [CNT_W-1:0] w_dv_rem   [F+1];
    logic [F-1:0]     w_dv_quo   [F+1];

    // index and linear terms
    logic [PRD_W-1:0]  w_ratio_m;
    logic [M_W-1:0]    w_idx_hi;
    logic [IDX_W-1:0]  w_idx;
    logic [COEF_W-1:0] w_pos, w_neg, w_y;
    logic [X_W-1:0]    w_lin;

    logic              r_s1_valid;
    logic [IDX_W-1:0]  r_s1_idx;
    t_tail             r_s1_tail;

    logic [P_W-1:0]    w_p;
    logic              r_s2_valid;
    t_tail             r_s2_tail;

    logic              r_s3_valid;
    logic [C_W-1:0]    r_s3_c;
    t_tail             r_s3_tail;

    logic              r_s4_valid;
    logic [BBC_W-1:0]  r_s4_prod;
    t_tail             r_s4_tail;

    logic [X_W-1:0]    w_x;

    assign w_en       = ~o_out_valid | i_out_ready;
    assign o_in_ready = w_en;

    // region select
    assign w_ir100 = COEF_W'(i_infrared_count) * COEF_W'(100);
    assign w_bb61  = COEF_W'(i_broadband_count) * COEF_W'(61);
    assign w_ir10  = COEF_W'(i_infrared_count) * COEF_W'(10);
    assign w_bb8   = COEF_W'(i_broadband_count) << 3;
    assign w_bb13  = COEF_W'(i_broadband_count) * COEF_W'(13);

    always_comb begin
        if (i_broadband_count == SAT_CODE || i_infrared_count == SAT_CODE
            || i_broadband_count == '0) begin
            w_region = RGN_NONE;
        end else if ({i_infrared_count, 1'b0} < {1'b0, i_broadband_count}) begin
            w_region = RGN_A;
        end else if (w_ir100 < w_bb61) begin
            w_region = RGN_B;
        end else if (w_ir10 < w_bb8) begin
            w_region = RGN_C;
        end else if (w_ir10 < w_bb13) begin
            w_region = RGN_D;
        end else begin
            w_region = RGN_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in_valid;
            r_s1_valid <= w_dv_valid[F];
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side.bb     <= i_broadband_count;
            r_s0_side.ir     <= i_infrared_count;
            r_s0_side.region <= w_region;
        end
    end

    // ratio divider, remainder starts at ir only for the table region
    assign w_dv_valid[0] = r_s0_valid;
    assign w_dv_side[0]  = r_s0_side;
    assign w_dv_rem[0]   = (r_s0_side.region == RGN_A) ? r_s0_side.ir : '0;
    assign w_dv_quo[0]   = '0;

    for (genvar gi = 0; gi < F; gi++) begin : g_div
        alc_div_stage #(
            .QUO_W (F)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_valid[gi]),
            .i_side  (w_dv_side[gi]),
            .i_rem   (w_dv_rem[gi]),
            .i_quo   (w_dv_quo[gi]),
            .o_valid (w_dv_valid[gi+1]),
            .o_side  (w_dv_side[gi+1]),
            .o_rem   (w_dv_rem[gi+1]),
            .o_quo   (w_dv_quo[gi+1])
        );
    end

    // table index
    assign w_ratio_m = PRD_W'(w_dv_quo[F]) * PRD_W'(TBL_M);
    assign w_idx_hi  = w_ratio_m[PRD_W-1 -: M_W];
    assign w_idx     = (w_idx_hi >= M_W'(POW_TABLE_ENTRIES))
                     ? IDX_W'(POW_TABLE_ENTRIES - 1) : w_idx_hi[IDX_W-1:0];

    // linear regions
    always_comb begin
        w_pos = '0;
        w_neg = '0;
        unique case (w_dv_side[F].region)
            RGN_B: begin
                w_pos = COEF_W'(w_dv_side[F].bb) * COEF_B_BB;
                w_neg = COEF_W'(w_dv_side[F].ir) * COEF_B_IR;
            end
            RGN_C: begin
                w_pos = COEF_W'(w_dv_side[F].bb) * COEF_C_BB;
                w_neg = COEF_W'(w_dv_side[F].ir) * COEF_C_IR;
            end
            RGN_D: begin
                w_pos = COEF_W'(w_dv_side[F].bb) * COEF_D_BB;
                w_neg = COEF_W'(w_dv_side[F].ir) * COEF_D_IR;
            end
            default: begin
                w_pos = '0;
                w_neg = '0;
            end
        endcase
    end

    assign w_y = w_pos - w_neg;

    always_comb begin
        w_lin = '0;
        if (w_pos > w_neg) begin
            unique case (w_dv_side[F].region)
                RGN_B:   w_lin = X_W'(w_y) << LIN_SH_B;
                RGN_C:   w_lin = X_W'(w_y) << LIN_SH_C;
                RGN_D:   w_lin = X_W'(w_y) << LIN_SH_D;
                default: w_lin = '0;
            endcase
        end
    end

    alc_pow_rom #(
        .POW_TABLE_ENTRIES (POW_TABLE_ENTRIES)
    ) u_pow_rom (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_idx (r_s1_idx),
        .o_p   (w_p)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_idx         <= w_idx;
            r_s1_tail.bb     <= w_dv_side[F].bb;
            r_s1_tail.lin    <= w_lin;
            r_s1_tail.region <= w_dv_side[F].region;

            r_s2_tail        <= r_s1_tail;

            r_s3_c           <= A_BASE - C_W'(COEF_W'(w_p) * COEF_A_P);
            r_s3_tail        <= r_s2_tail;

            r_s4_prod        <= BBC_W'(r_s3_tail.bb) * BBC_W'(r_s3_c);
            r_s4_tail        <= r_s3_tail;
        end
    end

    assign w_x = (r_s4_tail.region == RGN_A)
               ? r_s4_prod[A_SHIFT +: X_W] : r_s4_tail.lin;

    alc_const_div u_const_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s4_valid),
        .i_x     (w_x),
        .i_big   (r_s4_tail.region == RGN_D),
        .i_zero  (r_s4_tail.region == RGN_NONE),
        .o_valid (o_out_valid),
        .o_q     (o_lux_q8)
    );

endmodule

`default_nettype wire
